[rtl/core/height_grid_walkability_defines.svh]
// assertion macros shared by the block's checking code
`ifndef HEIGHT_GRID_WALKABILITY_DEFINES_SVH
`define HEIGHT_GRID_WALKABILITY_DEFINES_SVH

// same-cycle implication, disabled during reset
`define HGW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define HGW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/hgw_pkg.sv]
package hgw_pkg;

   // fixed field widths
   localparam int COORD_BITS      = 7;
   localparam int COUNT_BITS      = 7;
   localparam int DIM_BITS        = COORD_BITS + 1;
   localparam int IO_HEIGHT_BITS  = 16;
   localparam int CSR_INDEX_BITS  = 1;
   localparam int CSR_DATA_BITS   = COUNT_BITS;

   // default sizing
   localparam int DEF_MAX_DIM     = 64;
   localparam int DEF_HEIGHT_BITS = 16;

   // largest height change allowed in one step
   localparam int STEP_LIMIT      = 1;

   // register reset values
   localparam logic [COUNT_BITS-1:0] ROW_COUNT_RESET    = COUNT_BITS'(15);
   localparam logic [COUNT_BITS-1:0] COLUMN_COUNT_RESET = COUNT_BITS'(15);

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_COUNT    = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COLUMN_COUNT = CSR_INDEX_BITS'(1);

   // request opcodes
   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_QUERY = 2'd2
   } op_type;

   // request word
   typedef struct packed {
      op_type                            command;
      logic [COORD_BITS-1:0]             cell_row;
      logic [COORD_BITS-1:0]             cell_col;
      logic signed [IO_HEIGHT_BITS-1:0]  new_height;
      logic [COORD_BITS-1:0]             goal_row;
      logic [COORD_BITS-1:0]             goal_col;
   } req_type;

   // response word
   typedef struct packed {
      logic                              walkable;
      logic                              in_range;
      logic signed [IO_HEIGHT_BITS-1:0]  cell_height;
   } rsp_type;

   // store address source
   typedef enum logic [2:0] {
      SEL_CLEAR,
      SEL_REQ,
      SEL_GOAL,
      SEL_CA,
      SEL_CB
   } addr_sel_type;

   // controller to datapath
   typedef struct packed {
      logic         clear_wr;
      logic         req_take;
      logic         rd_en;
      addr_sel_type addr_sel;
      logic         cap_hs;
      logic         cap_hg;
      logic         cap_ha;
      logic         load_rsp;
   } hgw_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
   } hgw_status_type;

endpackage

[rtl/core/hgw_ctrl.sv]
module hgw_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  hgw_pkg::op_type        req_command,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  hgw_pkg::hgw_status_type status,
   output hgw_pkg::hgw_cmd_type    cmd
);
   import hgw_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_Q_GOAL,
      ST_Q_CA,
      ST_Q_CB,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      accept;
   logic      rsp_free;

   // handshake
   assign accept    = (state_ff == ST_IDLE) && req_valid;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   // datapath commands per state
   always_comb begin
      cmd          = '0;
      cmd.addr_sel = SEL_REQ;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            cmd.addr_sel = SEL_CLEAR;
         end
         ST_IDLE: begin
            cmd.req_take = accept;
            cmd.rd_en    = accept;
         end
         ST_Q_GOAL: begin
            cmd.cap_hs   = 1'b1;
            cmd.rd_en    = 1'b1;
            cmd.addr_sel = SEL_GOAL;
         end
         ST_Q_CA: begin
            cmd.cap_hg   = 1'b1;
            cmd.rd_en    = 1'b1;
            cmd.addr_sel = SEL_CA;
         end
         ST_Q_CB: begin
            cmd.cap_ha   = 1'b1;
            cmd.rd_en    = 1'b1;
            cmd.addr_sel = SEL_CB;
         end
         ST_FINISH: begin
            cmd.load_rsp = rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // state and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               if (status.clear_last) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= (req_command == OP_QUERY) ? ST_Q_GOAL : ST_FINISH;
               end
            end
            ST_Q_GOAL: state_ff <= ST_Q_CA;
            ST_Q_CA:   state_ff <= ST_Q_CB;
            ST_Q_CB:   state_ff <= ST_FINISH;
            ST_FINISH: begin
               if (rsp_free) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

[rtl/core/hgw_dp.sv]
module hgw_dp #(
   parameter int MAX_DIM     = hgw_pkg::DEF_MAX_DIM,
   parameter int HEIGHT_BITS = hgw_pkg::DEF_HEIGHT_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  hgw_pkg::req_type                    req_data,
   output hgw_pkg::rsp_type                    rsp_data,
   input  logic                                csr_wr_en,
   input  logic [hgw_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [hgw_pkg::CSR_DATA_BITS-1:0]   csr_wr_data,
   input  hgw_pkg::hgw_cmd_type                cmd,
   output hgw_pkg::hgw_status_type             status
);
   import hgw_pkg::*;

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int ROW_W  = $clog2(MAX_DIM);
   localparam int DIFF_W = HEIGHT_BITS + 1;
   localparam logic signed [DIFF_W-1:0] LIMIT     = DIFF_W'(STEP_LIMIT);
   localparam logic signed [DIFF_W-1:0] NEG_LIMIT = -LIMIT;

   logic signed [HEIGHT_BITS-1:0] height_mem_ff [DEPTH];
   logic signed [HEIGHT_BITS-1:0] rdata_ff;
   logic signed [HEIGHT_BITS-1:0] hs_ff;
   logic signed [HEIGHT_BITS-1:0] hg_ff;
   logic signed [HEIGHT_BITS-1:0] ha_ff;
   logic [COUNT_BITS-1:0]         row_count_ff;
   logic [COUNT_BITS-1:0]         column_count_ff;
   logic [ADDR_W-1:0]             clr_ff;
   req_type                       item_ff;
   rsp_type                       rsp_ff;
   rsp_type                       rsp_in;

   logic [DIM_BITS-1:0]           row_lim;
   logic [DIM_BITS-1:0]           col_lim;
   logic [ADDR_W-1:0]             mem_addr;
   logic                          mem_we;
   logic signed [HEIGHT_BITS-1:0] mem_wdata;
   logic                          start_in;
   logic                          goal_in;
   logic signed [DIFF_W-1:0]      d_sg;
   logic signed [DIFF_W-1:0]      d_a;
   logic signed [DIFF_W-1:0]      d_b;
   logic                          step_ok;
   logic                          row_adj;
   logic                          col_adj;
   logic                          corner_block;

   // grid bounds, counts above the store size clip to it
   assign row_lim = (DIM_BITS'(row_count_ff) > DIM_BITS'(MAX_DIM)) ?
                    DIM_BITS'(MAX_DIM) : DIM_BITS'(row_count_ff);
   assign col_lim = (DIM_BITS'(column_count_ff) > DIM_BITS'(MAX_DIM)) ?
                    DIM_BITS'(MAX_DIM) : DIM_BITS'(column_count_ff);

   function automatic logic cell_in_grid(input logic [COORD_BITS-1:0] r,
                                         input logic [COORD_BITS-1:0] c,
                                         input logic [DIM_BITS-1:0]   rl,
                                         input logic [DIM_BITS-1:0]   cl);
      return ({1'b0, r} < rl) && ({1'b0, c} < cl);
   endfunction

   // row-major address, cells outside the grid map to entry zero
   function automatic logic [ADDR_W-1:0] addr_of(input logic [COORD_BITS-1:0] r,
                                                 input logic [COORD_BITS-1:0] c,
                                                 input logic [DIM_BITS-1:0]   rl,
                                                 input logic [DIM_BITS-1:0]   cl);
      logic [ADDR_W-1:0] a;
      a = ADDR_W'(r[ROW_W-1:0]) * ADDR_W'(MAX_DIM) + ADDR_W'(c[ROW_W-1:0]);
      return cell_in_grid(r, c, rl, cl) ? a : '0;
   endfunction

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff    <= ROW_COUNT_RESET;
         column_count_ff <= COLUMN_COUNT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ROW_COUNT:    row_count_ff    <= csr_wr_data;
            CSR_COLUMN_COUNT: column_count_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // clearing sweep counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_wr) begin
         clr_ff <= clr_ff + ADDR_W'(1);
      end
   end
   assign status.clear_last = (clr_ff == ADDR_W'(DEPTH - 1));

   // store address select
   always_comb begin
      case (cmd.addr_sel)
         SEL_CLEAR: mem_addr = clr_ff;
         SEL_REQ:   mem_addr = addr_of(req_data.cell_row, req_data.cell_col, row_lim, col_lim);
         SEL_GOAL:  mem_addr = addr_of(item_ff.goal_row, item_ff.goal_col, row_lim, col_lim);
         SEL_CA:    mem_addr = addr_of(item_ff.goal_row, item_ff.cell_col, row_lim, col_lim);
         SEL_CB:    mem_addr = addr_of(item_ff.cell_row, item_ff.goal_col, row_lim, col_lim);
         default:   mem_addr = '0;
      endcase
   end

   // store write: clearing sweep or an in-grid write request
   assign mem_we = cmd.clear_wr ||
                   (cmd.req_take && (req_data.command == OP_WRITE) &&
                    cell_in_grid(req_data.cell_row, req_data.cell_col, row_lim, col_lim));
   assign mem_wdata = cmd.clear_wr ? '0 : HEIGHT_BITS'(req_data.new_height);

   // single-port height store, registered read
   always_ff @(posedge clock) begin
      if (mem_we) height_mem_ff[mem_addr] <= mem_wdata;
      if (cmd.rd_en) rdata_ff <= height_mem_ff[mem_addr];
   end

   // request and fetched heights
   always_ff @(posedge clock) begin
      if (cmd.req_take) item_ff <= req_data;
      if (cmd.cap_hs) hs_ff <= rdata_ff;
      if (cmd.cap_hg) hg_ff <= rdata_ff;
      if (cmd.cap_ha) ha_ff <= rdata_ff;
   end

   // walk check, last corner comes straight from the read register
   assign start_in = cell_in_grid(item_ff.cell_row, item_ff.cell_col, row_lim, col_lim);
   assign goal_in  = cell_in_grid(item_ff.goal_row, item_ff.goal_col, row_lim, col_lim);
   assign d_sg     = DIFF_W'(hs_ff) - DIFF_W'(hg_ff);
   assign d_a      = DIFF_W'(ha_ff) - DIFF_W'(hs_ff);
   assign d_b      = DIFF_W'(rdata_ff) - DIFF_W'(hs_ff);
   assign step_ok  = (d_sg <= LIMIT) && (d_sg >= NEG_LIMIT);
   assign row_adj  = ({1'b0, item_ff.goal_row} == {1'b0, item_ff.cell_row} + DIM_BITS'(1)) ||
                     ({1'b0, item_ff.cell_row} == {1'b0, item_ff.goal_row} + DIM_BITS'(1));
   assign col_adj  = ({1'b0, item_ff.goal_col} == {1'b0, item_ff.cell_col} + DIM_BITS'(1)) ||
                     ({1'b0, item_ff.cell_col} == {1'b0, item_ff.goal_col} + DIM_BITS'(1));
   assign corner_block = row_adj && col_adj && (d_a > LIMIT) && (d_b > LIMIT);

   // response word
   always_comb begin
      rsp_in = '0;
      case (item_ff.command)
         OP_WRITE: begin
            rsp_in.in_range = start_in;
         end
         OP_READ: begin
            rsp_in.in_range    = start_in;
            rsp_in.cell_height = start_in ? IO_HEIGHT_BITS'(rdata_ff) : '1;
         end
         OP_QUERY: begin
            rsp_in.in_range = start_in && goal_in;
            rsp_in.walkable = start_in && goal_in && step_ok && !corner_block;
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) rsp_ff <= rsp_in;
   end
   assign rsp_data = rsp_ff;

endmodule

[rtl/core/height_grid_walkability.sv]
// Height grid with step walkability checks. One height per cell sits in a single-port store
// of MAX_DIM x MAX_DIM entries, row-major; requests write a height, read one back, or ask
// whether a step from a start cell to a target cell is allowed. After reset the block sweeps
// the store to zero, one entry per cycle, and req_stall stays high until the sweep ends;
// csr writes are taken during the sweep. Every store access goes through the one port with a
// registered read, which sets the rate: a write or read goes from idle straight to the finish
// state, while a walk query first passes through the target and both corner fetch states
// (start, target and both corner cells are fetched one per cycle). A finished response waits
// in an output register while the next request is already accepted and worked on. Row and
// column counts above MAX_DIM act as MAX_DIM; csr writes belong to idle periods only.
`include "height_grid_walkability_defines.svh"

module height_grid_walkability #(
   parameter int MAX_DIM     = hgw_pkg::DEF_MAX_DIM,
   parameter int HEIGHT_BITS = hgw_pkg::DEF_HEIGHT_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  hgw_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output hgw_pkg::rsp_type                    rsp_data,
   input  logic                                csr_wr_en,
   input  logic [hgw_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [hgw_pkg::CSR_DATA_BITS-1:0]   csr_wr_data
);
   import hgw_pkg::*;

   hgw_cmd_type    cmd;
   hgw_status_type status;

   // sequencer
   hgw_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_data.command),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .status      (status),
      .cmd         (cmd)
   );

   // store, bounds and walk logic
   hgw_dp #(
      .MAX_DIM     (MAX_DIM),
      .HEIGHT_BITS (HEIGHT_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status)
   );

   // checks
   `HGW_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && !req_stall, req_stall, "request accepted while another is in progress")
   `HGW_ASSERT_NOW(a_no_rsp_overwrite, clock, reset, cmd.load_rsp, !rsp_valid || !rsp_stall, "pending response overwritten")
   `HGW_ASSERT_NOW(a_clear_blocks_req, clock, reset, cmd.clear_wr, req_stall && !cmd.req_take, "request taken during store clear")

endmodule
